// ----- hw/rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned SatW   = 9;
  localparam int unsigned ValW   = 9;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned KW     = 6;   // remainder within a sector, 0..59
  localparam int unsigned TermW  = 15;  // sat * k and sat * (60 - k)
  localparam int unsigned XW     = 17;  // signed term, units of 1/15360
  localparam int unsigned XPosW  = 14;  // positive term, at most 15360
  localparam int unsigned ProdW  = 23;  // value * term
  localparam int unsigned ScaleW = 28;  // 17 * value * term
  localparam int unsigned ShiftR = 18;  // 255 / 3932160 == 17 / 2^18

  localparam int unsigned SectorDeg = 60;
  localparam logic [HueW-1:0] HueWrap = 9'd360;
  localparam logic signed [XW-1:0] FullX = 17'sd15360;
  localparam logic signed [XW-1:0] UnitSat = 17'sd256;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  // stage advance enables handed to the channel slices
  typedef struct packed {
    logic en_mul;
    logic en_out;
  } adv_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Request channels of the converter: HSV in, RGB out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsv2rgb_pkg::HueW-1:0]  hue;
  logic [hsv2rgb_pkg::SatW-1:0]  saturation;
  logic [hsv2rgb_pkg::ValW-1:0]  brightness_value;

  modport source (output valid, hue, saturation, brightness_value, input ready);
  modport sink   (input valid, hue, saturation, brightness_value, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsv2rgb_pkg::ChanW-1:0] red;
  logic [hsv2rgb_pkg::ChanW-1:0] green;
  logic [hsv2rgb_pkg::ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Stateless HSV to 8-bit RGB converter, four register stages.
// ----------------------------------------------------------------------------
// Stages: an accepted request passes, in order, the register stages
//   sector split, term select, multiply and scale/clamp.
// Throughput: one request per cycle; the per-channel 9x14 multiplier sets
//   the stage depth. A stall on the output holds the full stages in place
//   while empty stages upstream still fill.
// Reset: rst_ni clears the stage valid bits only; no other state is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  hsv2rgb_in_if.sink       hsv_i,
  hsv2rgb_out_if.source    rgb_o
);

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || rgb_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign hsv_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= hsv_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: fold hue into 0..359, split into sector and remainder k.
  // Hue 360..511 wraps once.
  // --------------------------------------------------------------------------
  logic [hsv2rgb_pkg::HueW-1:0] hue_w;
  logic [hsv2rgb_pkg::HueW-1:0] base;
  hsv2rgb_pkg::sector_e         sec_d, sec1_q;
  logic [hsv2rgb_pkg::KW-1:0]   k_d, k1_q;
  logic [hsv2rgb_pkg::SatW-1:0] sat1_q;
  logic [hsv2rgb_pkg::ValW-1:0] val1_q;

  assign hue_w = (hsv_i.hue >= hsv2rgb_pkg::HueWrap) ? hsv_i.hue - hsv2rgb_pkg::HueWrap
                                                     : hsv_i.hue;

  always_comb begin
    if (hue_w >= hsv2rgb_pkg::HueW'(5 * hsv2rgb_pkg::SectorDeg)) begin
      sec_d = hsv2rgb_pkg::SecMagRed;
      base  = hsv2rgb_pkg::HueW'(5 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w >= hsv2rgb_pkg::HueW'(4 * hsv2rgb_pkg::SectorDeg)) begin
      sec_d = hsv2rgb_pkg::SecBluMag;
      base  = hsv2rgb_pkg::HueW'(4 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w >= hsv2rgb_pkg::HueW'(3 * hsv2rgb_pkg::SectorDeg)) begin
      sec_d = hsv2rgb_pkg::SecCynBlu;
      base  = hsv2rgb_pkg::HueW'(3 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w >= hsv2rgb_pkg::HueW'(2 * hsv2rgb_pkg::SectorDeg)) begin
      sec_d = hsv2rgb_pkg::SecGrnCyn;
      base  = hsv2rgb_pkg::HueW'(2 * hsv2rgb_pkg::SectorDeg);
    end else if (hue_w >= hsv2rgb_pkg::HueW'(hsv2rgb_pkg::SectorDeg)) begin
      sec_d = hsv2rgb_pkg::SecYelGrn;
      base  = hsv2rgb_pkg::HueW'(hsv2rgb_pkg::SectorDeg);
    end else begin
      sec_d = hsv2rgb_pkg::SecRedYel;
      base  = '0;
    end
  end

  assign k_d = hsv2rgb_pkg::KW'(hue_w - base);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q <= sec_d;
      k1_q   <= k_d;
      sat1_q <= hsv_i.saturation;
      val1_q <= hsv_i.brightness_value;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: form p, q, t in units of 1/15360 (v is the full unit) and route
  // them to the channels by sector. Saturation above 1.0 can push a term
  // negative; the channel slice turns that into zero.
  // --------------------------------------------------------------------------
  logic [hsv2rgb_pkg::KW-1:0]           k_c;
  logic [hsv2rgb_pkg::TermW-1:0]        sk, skc;
  logic signed [hsv2rgb_pkg::XW-1:0]    sat_diff, xp, xq, xt;
  logic signed [hsv2rgb_pkg::XW-1:0]    xr_d, xg_d, xb_d, xr_q, xg_q, xb_q;
  logic [hsv2rgb_pkg::ValW-1:0]         val2_q;

  assign k_c      = hsv2rgb_pkg::KW'(hsv2rgb_pkg::SectorDeg) - k1_q;
  assign sk       = hsv2rgb_pkg::TermW'(sat1_q) * hsv2rgb_pkg::TermW'(k1_q);
  assign skc      = hsv2rgb_pkg::TermW'(sat1_q) * hsv2rgb_pkg::TermW'(k_c);
  assign sat_diff = hsv2rgb_pkg::UnitSat - signed'(hsv2rgb_pkg::XW'(sat1_q));
  assign xp       = hsv2rgb_pkg::XW'(sat_diff * signed'(hsv2rgb_pkg::XW'(
                      hsv2rgb_pkg::SectorDeg)));
  assign xq       = hsv2rgb_pkg::FullX - signed'(hsv2rgb_pkg::XW'(sk));
  assign xt       = hsv2rgb_pkg::FullX - signed'(hsv2rgb_pkg::XW'(skc));

  always_comb begin
    case (sec1_q)
      hsv2rgb_pkg::SecRedYel: begin
        xr_d = hsv2rgb_pkg::FullX; xg_d = xt; xb_d = xp;
      end
      hsv2rgb_pkg::SecYelGrn: begin
        xr_d = xq; xg_d = hsv2rgb_pkg::FullX; xb_d = xp;
      end
      hsv2rgb_pkg::SecGrnCyn: begin
        xr_d = xp; xg_d = hsv2rgb_pkg::FullX; xb_d = xt;
      end
      hsv2rgb_pkg::SecCynBlu: begin
        xr_d = xp; xg_d = xq; xb_d = hsv2rgb_pkg::FullX;
      end
      hsv2rgb_pkg::SecBluMag: begin
        xr_d = xt; xg_d = xp; xb_d = hsv2rgb_pkg::FullX;
      end
      default: begin
        xr_d = hsv2rgb_pkg::FullX; xg_d = xp; xb_d = xq;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      xr_q   <= xr_d;
      xg_q   <= xg_d;
      xb_q   <= xb_d;
      val2_q <= val1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: per-channel multiply, then * 255 / 3932160 (== * 17 >> 18)
  // with saturation at 255.
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::adv_t adv;

  assign adv.en_mul = en3;
  assign adv.en_out = en4;

  hsv2rgb_chan u_red (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (val2_q),
    .x_i    (xr_q),
    .chan_o (rgb_o.red)
  );

  hsv2rgb_chan u_green (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (val2_q),
    .x_i    (xg_q),
    .chan_o (rgb_o.green)
  );

  hsv2rgb_chan u_blue (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (val2_q),
    .x_i    (xb_q),
    .chan_o (rgb_o.blue)
  );

  assign rgb_o.valid = v4_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_chan.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// One color channel: value * term, then * 17 >> 18 with clamp to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_chan (
  input  wire                                   clk_i,
  input  hsv2rgb_pkg::adv_t                     adv_i,
  input  wire        [hsv2rgb_pkg::ValW-1:0]    val_i,
  input  wire signed [hsv2rgb_pkg::XW-1:0]      x_i,
  output logic       [hsv2rgb_pkg::ChanW-1:0]   chan_o
);

  logic [hsv2rgb_pkg::XPosW-1:0]  x_pos;
  logic [hsv2rgb_pkg::ProdW-1:0]  prod_d, prod_q;
  logic [hsv2rgb_pkg::ScaleW-1:0] scaled;
  logic [hsv2rgb_pkg::ScaleW-hsv2rgb_pkg::ShiftR-1:0] quot;
  logic [hsv2rgb_pkg::ChanW-1:0]  chan_d, chan_q;

  // non-positive term gives a black channel
  assign x_pos  = (x_i <= 0) ? '0 : x_i[hsv2rgb_pkg::XPosW-1:0];
  assign prod_d = hsv2rgb_pkg::ProdW'(val_i) * hsv2rgb_pkg::ProdW'(x_pos);

  // 17 * p as shift-add
  assign scaled = {prod_q, 4'b0000} + hsv2rgb_pkg::ScaleW'(prod_q);
  assign quot   = scaled[hsv2rgb_pkg::ScaleW-1:hsv2rgb_pkg::ShiftR];
  assign chan_d = (quot > hsv2rgb_pkg::ChanMax) ? hsv2rgb_pkg::ChanMax
                                                : quot[hsv2rgb_pkg::ChanW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv_i.en_mul) begin
      prod_q <= prod_d;
    end
    if (adv_i.en_out) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the converter's flow control and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // with the output slot free, the whole pipe can move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input blocked while output drains");

  // a request accepted while the output keeps draining has passed every
  // stage and is on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc, 4) && $past(out_ready_i, 3) && $past(out_ready_i, 2) &&
    $past(out_ready_i, 1) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
    $past(rst_ni, 2) && $past(rst_ni, 1) |-> out_valid_i)
    else $error("result missing after pipeline latency");

  // an empty output slot lets every stage move, so while it stays empty the
  // output only carries a request that has gone through every stage
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_valid_i, 4) && !$past(out_valid_i, 3) && !$past(out_valid_i, 2) &&
    !$past(out_valid_i, 1) && !$past(in_valid_i, 4) |-> !out_valid_i)
    else $error("result without request");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready)
);

`default_nettype wire

// ----- tb/sv/hsv_to_rgb_converter_top_test.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_test
// Self-checking bench for the HSV to RGB converter: directed corner colors,
// then about 400 random requests, each checked against a local model.
// Random idling on both sides, one long output stall and a full drain mid-run.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  // Timing and run length
  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned CalmItems   = 60;      // tail of the run without idling
  localparam int unsigned HoldItem    = 100;     // where the long output stall starts
  localparam int unsigned DrainItem   = 220;     // where the sender waits for a full drain
  localparam int unsigned SteadyItems = 24;      // back-to-back requests during the stall
  localparam int unsigned LongHold    = 64;
  localparam int unsigned TailCycles  = 12;      // wait after the final drain for stray results
  localparam int unsigned DrainGuard  = 2000;
  localparam int unsigned LimitCycles = 200000;

  // Fixed-point constants of the conversion: terms are in units of 1/15360
  localparam longint HueTurn   = 360;
  localparam longint HueSector = 60;
  localparam longint FullTerm  = 15360;
  localparam longint UnitSatL  = 256;
  localparam longint ChanScale = 255;
  localparam longint UnitDen   = 3932160;        // 256 * 15360
  localparam longint ChanTop   = 255;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [ValW-1:0] brightness_value;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the color of each accepted request and matches the
  // results in order.
  // --------------------------------------------------------------------------
  class color_scoreboard;
    rgb_t        pending_rgb_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned results;
    int unsigned off_range;

    // floor(255 * V * X / 3932160), clamped to 0..255
    function logic [ChanW-1:0] scale_channel(longint val, longint term);
      longint prod;
      prod = ChanScale * val * term;
      if (prod <= 0) return '0;
      prod = prod / UnitDen;
      if (prod > ChanTop) return ChanMax;
      return prod[ChanW-1:0];
    endfunction

    function rgb_t hsv_to_rgb(hsv_t c);
      longint  h, s, v, k, tv, tp, tq, tt;
      sector_e sec;
      rgb_t    r;
      h = longint'(c.hue);
      s = longint'(c.saturation);
      v = longint'(c.brightness_value);
      if (h >= HueTurn) h = h - HueTurn;   // single wrap: 360..511 -> 0..151
      sec = sector_e'(h / HueSector);
      k   = h % HueSector;
      tv = FullTerm;
      tp = HueSector * (UnitSatL - s);
      tq = FullTerm - s * k;
      tt = FullTerm - s * (HueSector - k);
      case (sec)
        SecRedYel: r = '{scale_channel(v, tv), scale_channel(v, tt), scale_channel(v, tp)};
        SecYelGrn: r = '{scale_channel(v, tq), scale_channel(v, tv), scale_channel(v, tp)};
        SecGrnCyn: r = '{scale_channel(v, tp), scale_channel(v, tv), scale_channel(v, tt)};
        SecCynBlu: r = '{scale_channel(v, tp), scale_channel(v, tq), scale_channel(v, tv)};
        SecBluMag: r = '{scale_channel(v, tt), scale_channel(v, tp), scale_channel(v, tv)};
        default: r = '{scale_channel(v, tv), scale_channel(v, tp), scale_channel(v, tq)};
      endcase
      return r;
    endfunction

    function void note_request(hsv_t c);
      requests++;
      if (c.hue >= HueTurn || c.saturation > UnitSatL || c.brightness_value > UnitSatL)
        off_range++;
      pending_rgb_q.push_back(hsv_to_rgb(c));
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      results++;
      if (pending_rgb_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = pending_rgb_q.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_rgb_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  hsv2rgb_in_if  hsv ();
  hsv2rgb_out_if rgb ();

  hsv_to_rgb_converter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv),
    .rgb_o  (rgb)
  );

  color_scoreboard colors;

  // Shared run controls
  logic        hold_request = 1'b0;  // sender asks the receiver for a long stall
  bit          calm = 1'b0;          // no idling on either side
  int unsigned steady_left = 0;      // requests left to send without gaps
  int unsigned cycle_count = 0;

  // Watchdog: a hang ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed corner colors: every sector edge at full saturation, grey and
  // black, hue wrap above 359, saturation above 1.0 (negative terms) and
  // value above 1.0 (clamped channels), plus all-zero and all-ones fields.
  hsv_t corner_colors [23] = '{
    '{9'd0,   9'd256, 9'd256}, '{9'd59,  9'd256, 9'd256}, '{9'd60,  9'd256, 9'd256},
    '{9'd119, 9'd256, 9'd256}, '{9'd120, 9'd256, 9'd256}, '{9'd179, 9'd256, 9'd256},
    '{9'd180, 9'd256, 9'd256}, '{9'd239, 9'd256, 9'd256}, '{9'd240, 9'd256, 9'd256},
    '{9'd299, 9'd256, 9'd256}, '{9'd300, 9'd256, 9'd256}, '{9'd359, 9'd256, 9'd256},
    '{9'd30,  9'd0,   9'd256}, '{9'd200, 9'd128, 9'd0},   '{9'd360, 9'd256, 9'd256},
    '{9'd511, 9'd256, 9'd256}, '{9'd90,  9'd511, 9'd256}, '{9'd45,  9'd257, 9'd200},
    '{9'd150, 9'd300, 9'd511}, '{9'd330, 9'd128, 9'd511}, '{9'd255, 9'd170, 9'd85},
    '{9'd0,   9'd0,   9'd0},   '{9'd511, 9'd511, 9'd511}
  };

  // Mostly nominal colors, with a bias toward sector edges and the ends of
  // saturation and value; about one in five uses the full 9-bit fields.
  function automatic hsv_t draw_color();
    hsv_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    c.hue              = HueW'($urandom_range(0, 359));
    c.saturation       = SatW'($urandom_range(0, 256));
    c.brightness_value = ValW'($urandom_range(0, 256));
    if (pick == 0) begin
      c.saturation = $urandom_range(0, 1) ? 9'd256 : 9'd0;
    end else if (pick == 1) begin
      c.brightness_value = $urandom_range(0, 1) ? 9'd256 : 9'd0;
    end else if (pick == 2) begin
      c.hue = HueW'(HueSector * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0));
    end else if (pick >= 8) begin
      c.hue              = HueW'($urandom_range(0, 511));
      c.saturation       = SatW'($urandom_range(0, 511));
      c.brightness_value = ValW'($urandom_range(0, 511));
    end
    return c;
  endfunction

  // Offer one request and hold it until accepted; then maybe idle a burst.
  // valid stays high when the next request follows directly.
  task automatic send_color(input hsv_t c);
    hsv.valid            <= 1'b1;
    hsv.hue              <= c.hue;
    hsv.saturation       <= c.saturation;
    hsv.brightness_value <= c.brightness_value;
    @(posedge clk_i);
    while (!hsv.ready) @(posedge clk_i);
    colors.note_request(c);
    if (!calm && steady_left == 0 && $urandom_range(0, 7) == 0) begin
      hsv.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Stop sending until every expected color is back, bounded by a guard.
  task automatic drain_colors();
    int unsigned guard;
    guard = 0;
    hsv.valid <= 1'b0;
    while (colors.pending() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks every accepted result, idles in random bursts, and
  // serves the long stall that the sender asks for.
  // --------------------------------------------------------------------------
  initial begin : receive_proc
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left  = 0;
    hold_left = 0;
    rgb.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rgb.valid && rgb.ready)
        colors.check_result(rgb_t'({rgb.red, rgb.green, rgb.blue}));
      if (hold_request) begin
        hold_left = LongHold;
        hold_request <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rgb.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        rgb.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 9) - 1;
        rgb.ready <= 1'b0;
      end else begin
        rgb.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and run sequence
  // --------------------------------------------------------------------------
  initial begin : main_proc
    colors = new();
    rst_ni <= 1'b0;
    hsv.valid            <= 1'b0;
    hsv.hue              <= '0;
    hsv.saturation       <= '0;
    hsv.brightness_value <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    foreach (corner_colors[i]) send_color(corner_colors[i]);

    // random requests
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == HoldItem) begin
        // receiver stalls for a long stretch while requests keep coming,
        // so the pipeline fills and backs up onto the input
        hold_request <= 1'b1;
        steady_left = SteadyItems;
      end
      if (i == DrainItem) drain_colors();
      if (i == RandomItems - CalmItems) calm = 1'b1;
      send_color(draw_color());
      if (steady_left != 0) steady_left--;
    end

    // wait out the pipeline, then a few cycles for anything stray
    drain_colors();
    repeat (TailCycles) @(posedge clk_i);
    if (colors.pending() != 0) begin
      $error("%0d expected colors never arrived", colors.pending());
      colors.mismatches++;
    end

    $display("Converted %0d colors (%0d with hue, saturation or value off the nominal range),",
             colors.requests, colors.requests == 0 ? 0 : colors.off_range);
    $display("%0d results checked across all six sectors, long output stall and full drain.",
             colors.results);
    if (colors.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_if.sv
hw/rtl/hsv2rgb_chan.sv
hw/rtl/hsv_to_rgb_converter_top.sv
hw/rtl/hsv2rgb_checker.sv
tb/sv/hsv_to_rgb_converter_top_test.sv
